>>> hdl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } t_cmd;

endpackage

>>> hdl/bounded_deque_engine_unit.sv
`timescale 1ns / 1ps
// the result strobe o_valid is high in S_RESP, which follows S_EXEC and S_LOAD after the accepting edge
// busy is high in S_EXEC, S_LOAD and S_RESP; a new transaction is accepted only in S_IDLE
// S_LOAD waits for the registered read of the entry ram for the new front or back
// reset (i_rst_n low, synchronous) empties the deque and returns the controller to idle
// the receiver cannot stall; each result is shown for exactly one cycle
module bounded_deque_engine_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [bdq_pkg::MODE_W-1:0]  i_mode,
    input  logic [bdq_pkg::DATA_W-1:0]  i_value,
    output logic                        busy,
    output logic                        o_valid,
    output logic [bdq_pkg::STAT_W-1:0]  o_status,
    output logic [bdq_pkg::DATA_W-1:0]  o_popped_value,
    output logic [bdq_pkg::CNT_W-1:0]   o_count,
    output logic                        o_is_empty,
    output logic [bdq_pkg::DATA_W-1:0]  o_front_value,
    output logic [bdq_pkg::DATA_W-1:0]  o_back_value
);
    import bdq_pkg::*;

    t_cmd cmd;

    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    bdq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

endmodule

>>> hdl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_valid,
    output bdq_pkg::t_cmd o_cmd
);
    import bdq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_LOAD;
            S_LOAD: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.load   = (r_state == S_LOAD);
    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_RESP);

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.exec)
        else $error("accepted transaction did not execute");

    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_cmd.load))
        else $error("result strobe without load");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !o_busy)
        else $error("result strobe longer than one cycle");
`endif

endmodule

>>> hdl/bdq_datapath.sv
`timescale 1ns / 1ps

module bdq_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bdq_pkg::t_cmd                i_cmd,
    input  logic [bdq_pkg::MODE_W-1:0]   i_mode,
    input  logic [bdq_pkg::DATA_W-1:0]   i_value,
    output logic [bdq_pkg::STAT_W-1:0]   o_status,
    output logic [bdq_pkg::DATA_W-1:0]   o_popped_value,
    output logic [bdq_pkg::CNT_W-1:0]    o_count,
    output logic                         o_is_empty,
    output logic [bdq_pkg::DATA_W-1:0]   o_front_value,
    output logic [bdq_pkg::DATA_W-1:0]   o_back_value
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    t_mode             r_mode;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_rd_data;

    logic [ADDR_W-1:0] r_head,    n_head;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic [DATA_W-1:0] r_front,   n_front;
    logic [DATA_W-1:0] r_back,    n_back;
    logic [DATA_W-1:0] r_popped,  n_popped;
    t_status           r_status,  n_status;
    logic              r_ld_front, n_ld_front;
    logic              r_ld_back,  n_ld_back;

    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] tail_next;
    logic [ADDR_W-1:0] tail_prev;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // head plus offset, wrapped once around the ring
    function automatic logic [ADDR_W-1:0] ring_idx(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  ofs);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, ofs};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign full      = (r_count == CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_dec  = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc  = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = ring_idx(r_head, r_count);
    assign tail_prev = ring_idx(r_head, r_count - CNT_W'(2));

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_front    = r_front;
        n_back     = r_back;
        n_popped   = r_popped;
        n_status   = r_status;
        n_ld_front = r_ld_front;
        n_ld_back  = r_ld_back;
        wr_en      = 1'b0;
        wr_addr    = tail_next;
        rd_addr    = head_inc;
        if (i_cmd.exec) begin
            n_popped   = '0;
            n_status   = ST_DONE;
            n_ld_front = 1'b0;
            n_ld_back  = 1'b0;
            unique case (r_mode)
                MODE_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_head  = head_dec;
                        n_count = r_count + 1'b1;
                        n_front = r_value;
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        if (empty) begin
                            n_back = r_value;
                        end
                    end
                end
                MODE_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_back  = r_value;
                        wr_en   = 1'b1;
                        wr_addr = tail_next;
                        if (empty) begin
                            n_front = r_value;
                        end
                    end
                end
                MODE_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped   = r_front;
                        n_head     = head_inc;
                        n_count    = r_count - 1'b1;
                        rd_addr    = head_inc;
                        n_ld_front = (r_count != CNT_W'(1));
                    end
                end
                MODE_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped  = r_back;
                        n_count   = r_count - 1'b1;
                        rd_addr   = tail_prev;
                        n_ld_back = (r_count != CNT_W'(1));
                    end
                end
                default: n_status = ST_DONE;
            endcase
        end
        if (i_cmd.load) begin
            if (r_ld_front) begin
                n_front = r_rd_data;
            end
            if (r_ld_back) begin
                n_back = r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_status   <= ST_DONE;
            r_ld_front <= 1'b0;
            r_ld_back  <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_status   <= n_status;
            r_ld_front <= n_ld_front;
            r_ld_back  <= n_ld_back;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_back   <= n_back;
        r_popped <= n_popped;
        if (i_cmd.accept) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_count        = r_count;
    assign o_is_empty     = empty;
    assign o_front_value  = empty ? '0 : r_front;
    assign o_back_value   = empty ? '0 : r_back;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && empty && (r_mode == MODE_POP_FRONT || r_mode == MODE_POP_BACK)
        |=> r_status == ST_EMPTY && r_count == '0 && $stable(r_head))
        else $error("pop on empty deque changed state");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && full && (r_mode == MODE_PUSH_FRONT || r_mode == MODE_PUSH_BACK)
        |=> r_status == ST_FULL && $stable(r_count) && $stable(r_head))
        else $error("push on full deque changed state");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count) && $stable(r_head))
        else $error("pointer moved outside execute");
`endif

endmodule

>>> verif/bdq_result_checker.sv
`timescale 1ns / 1ps

module bdq_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [bdq_pkg::MODE_W-1:0] i_mode,
    input  logic [bdq_pkg::DATA_W-1:0] i_value,
    input  logic                       i_valid,
    input  logic [bdq_pkg::STAT_W-1:0] i_status,
    input  logic [bdq_pkg::DATA_W-1:0] i_popped_value,
    input  logic [bdq_pkg::CNT_W-1:0]  i_count,
    input  logic                       i_is_empty,
    input  logic [bdq_pkg::DATA_W-1:0] i_front_value,
    input  logic [bdq_pkg::DATA_W-1:0] i_back_value,
    output int                         o_fail_count,
    output int                         o_pending,
    output logic [bdq_pkg::CNT_W-1:0]  o_level
);
    import bdq_pkg::*;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] popped;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] back;
    } t_deque_view;

    logic [DATA_W-1:0] ring_words [DEPTH];
    int unsigned       head_idx;
    int unsigned       occupancy;
    t_deque_view       expected_views [$];

    function automatic int unsigned ring_slot(int unsigned offset);
        return (head_idx + offset) % DEPTH;
    endfunction

    // updates the shadow deque and returns what the block should report
    function automatic t_deque_view apply_deque_op(t_mode op, logic [DATA_W-1:0] word);
        t_deque_view view;
        view.status = ST_DONE;
        view.popped = '0;
        view.front  = '0;
        view.back   = '0;
        case (op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (occupancy >= DEPTH) begin
                    view.status = ST_FULL;
                end else if (op == MODE_PUSH_FRONT) begin
                    head_idx = ring_slot(DEPTH - 1);
                    ring_words[head_idx] = word;
                    occupancy++;
                end else begin
                    ring_words[ring_slot(occupancy)] = word;
                    occupancy++;
                end
            end
            default: begin
                if (occupancy == 0) begin
                    view.status = ST_EMPTY;
                end else if (op == MODE_POP_FRONT) begin
                    view.popped = ring_words[head_idx];
                    head_idx = ring_slot(1);
                    occupancy--;
                end else begin
                    view.popped = ring_words[ring_slot(occupancy - 1)];
                    occupancy--;
                end
            end
        endcase
        if (occupancy != 0) begin
            view.front = ring_words[head_idx];
            view.back  = ring_words[ring_slot(occupancy - 1)];
        end
        view.count = CNT_W'(occupancy);
        view.empty = (occupancy == 0);
        return view;
    endfunction

    task automatic log_failure(string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_deque_view want;
        if (!i_rst_n) begin
            head_idx = 0;
            occupancy = 0;
            expected_views.delete();
        end else begin
            if (i_valid) begin
                if (expected_views.size() == 0) begin
                    log_failure("result transaction with nothing outstanding");
                end else begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    if (i_status !== want.status || i_popped_value !== want.popped ||
                        i_count !== want.count || i_is_empty !== want.empty ||
                        i_front_value !== want.front || i_back_value !== want.back)
                        log_failure($sformatf({"mismatch exp st=%0d pop=%h cnt=%0d emp=%b ",
                            "fr=%h bk=%h / got st=%0d pop=%h cnt=%0d emp=%b fr=%h bk=%h"},
                            want.status, want.popped, want.count, want.empty, want.front,
                            want.back, i_status, i_popped_value, i_count, i_is_empty,
                            i_front_value, i_back_value));
                end
            end
            if (i_start && !i_busy)
                expected_views = {expected_views, apply_deque_op(t_mode'(i_mode), i_value)};
        end
        o_pending = expected_views.size();
        o_level = CNT_W'(occupancy);
    end

endmodule

>>> verif/bounded_deque_engine_unit_test.sv
`timescale 1ns / 1ps

module bounded_deque_engine_unit_test;
    import bdq_pkg::*;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic [MODE_W-1:0] i_mode  = MODE_PUSH_FRONT;
    logic [DATA_W-1:0] i_value = '0;

    logic              busy;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [DATA_W-1:0] o_popped_value;
    logic [CNT_W-1:0]  o_count;
    logic              o_is_empty;
    logic [DATA_W-1:0] o_front_value;
    logic [DATA_W-1:0] o_back_value;

    int                fail_count;
    int                pending;
    logic [CNT_W-1:0]  level;
    bit                gapless;
    int unsigned       issued;

    bounded_deque_engine_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

    bdq_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_popped_value (o_popped_value),
        .i_count        (o_count),
        .i_is_empty     (o_is_empty),
        .i_front_value  (o_front_value),
        .i_back_value   (o_back_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_level        (level)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (gapless || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_op(t_mode op, logic [DATA_W-1:0] word, int unsigned gap);
        if (gap != 0) begin
            start   <= 1'b0;
            i_mode  <= MODE_W'($urandom);
            i_value <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= op;
        i_value <= word;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        issued++;
    endtask

    task automatic send_random_op(int unsigned push_pct);
        t_mode             op;
        logic [DATA_W-1:0] word;
        if ($urandom_range(0, 99) < push_pct) begin
            if ($urandom_range(0, 1) != 0) op = MODE_PUSH_BACK;
            else                           op = MODE_PUSH_FRONT;
        end else begin
            if ($urandom_range(0, 1) != 0) op = MODE_POP_BACK;
            else                           op = MODE_POP_FRONT;
        end
        case ($urandom_range(0, 9))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
        endcase
        send_op(op, word, pick_gap());
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pops on empty, both ends, extreme words, wrap of the head pointer
        send_op(MODE_POP_FRONT,  '0,            0);
        send_op(MODE_POP_BACK,   '1,            0);
        send_op(MODE_PUSH_FRONT, '1,            0);
        send_op(MODE_PUSH_BACK,  '0,            1);
        send_op(MODE_PUSH_FRONT, 32'hA5A5_A5A5, 0);
        send_op(MODE_PUSH_BACK,  32'h5A5A_5A5A, 2);
        send_op(MODE_POP_BACK,   '0,            0);
        send_op(MODE_POP_FRONT,  '1,            0);
        send_op(MODE_POP_FRONT,  '0,            0);
        send_op(MODE_POP_BACK,   '0,            3);
        send_op(MODE_POP_BACK,   '0,            0);
        send_op(MODE_PUSH_BACK,  32'h8000_0001, 0);
        send_op(MODE_POP_FRONT,  '0,            0);
        send_op(MODE_PUSH_FRONT, 32'h0000_0001, 1);
        send_op(MODE_POP_BACK,   '0,            0);
        send_op(MODE_POP_FRONT,  '0,            0);
        wait_drained();

        // churn around empty
        for (int i = 0; i < 100; i++) begin
            gapless = (i >= 40 && i < 80);
            send_random_op(50);
        end
        wait_drained();

        // fill up to full with mixed ends
        while (level < DEPTH) begin
            gapless = ((issued / 64) % 3 == 1);
            send_random_op(94);
        end

        // refused pushes and churn near full
        for (int i = 0; i < 60; i++) begin
            gapless = (i < 20);
            send_random_op(80);
        end
        for (int i = 0; i < 100; i++) begin
            gapless = (i >= 50);
            send_random_op(50);
        end
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
